// ===== hw/rtl/bdmm_pkg.sv =====
// ----------------------------------------------------------------------------
// bdmm_pkg: shared types of the block downsampler
// Command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bdmm_pkg;

   typedef struct packed {
      logic accept;  // take one sample beat
      logic start;   // latch mean magnitude, init class scan
      logic step;    // one class scan step, mean multiply
      logic load;    // latch result, clear block state
   } cmd_type;

   typedef struct packed {
      logic last_sample;  // next accepted beat completes the footprint
      logic step_last;    // final class scan step in progress
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bdmm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdmm_ctrl: sequencer of the block downsampler
// Collects a footprint, runs the finishing steps, hands the result to the
// output register when it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module bdmm_ctrl
   import bdmm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam logic [1:0] ST_ACC  = 2'd0;
   localparam logic [1:0] ST_INIT = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_ACC);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_ACC: begin
            cmd.accept = req_valid;
            if (req_valid && status.last_sample) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.start = 1'b1;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (status.step_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_ACC;
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/bdmm_datapath.sv =====
// ----------------------------------------------------------------------------
// bdmm_datapath: datapath of the block downsampler
// Insertion-sort cells, height sum with reciprocal-multiply mean, class
// counters with serial majority scan, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdmm_datapath
   import bdmm_pkg::*;
#(
   parameter int SAMPLES_PER_SIDE = 4,
   parameter int CLASS_COUNT      = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output status_type              status,
   input  wire logic               median_mode,
   input  wire logic signed [15:0] req_sample_height,
   input  wire logic        [7:0]  req_sample_class,
   output logic signed      [15:0] rsp_block_height,
   output logic             [3:0]  rsp_block_class
);

   localparam int FOOT = SAMPLES_PER_SIDE * SAMPLES_PER_SIDE;
   localparam int CNTW = $clog2(FOOT + 1);
   localparam int SUMW = 16 + $clog2(FOOT);
   localparam int CW   = $clog2(CLASS_COUNT);
   localparam int CLW  = (CW > 4) ? CW : 4;
   localparam int LAST = CLASS_COUNT - 1;
   localparam int STW  = $clog2(LAST + 1);

   // sample count and height sum
   logic        [CNTW-1:0] count_ff, count_in;
   logic signed [SUMW-1:0] sum_ff, sum_in;

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      if (cmd.load) begin
         count_in = '0;
         sum_in   = '0;
      end else if (cmd.accept) begin
         count_in = count_ff + 1'b1;
         sum_in   = sum_ff + SUMW'(req_sample_height);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   assign status.last_sample = (count_ff == CNTW'(FOOT - 1));

   // insertion-sort cells, ascending; cells at or past the count act as +inf
   logic signed [15:0] cell_ff [FOOT];
   logic signed [15:0] cell_in [FOOT];
   logic [FOOT-1:0]    gt;

   for (genvar g = 0; g < FOOT; g++) begin : g_cell
      assign gt[g] = (CNTW'(g) >= count_ff) || (cell_ff[g] > req_sample_height);
      if (g == 0) begin : g_first
         assign cell_in[g] = gt[g] ? req_sample_height : cell_ff[g];
      end else begin : g_rest
         assign cell_in[g] = !gt[g]     ? cell_ff[g] :
                             !gt[g - 1] ? req_sample_height : cell_ff[g - 1];
      end
      always_ff @(posedge clock) begin
         if (cmd.accept) begin
            cell_ff[g] <= cell_in[g];
         end
      end
   end

   // class counters
   logic [CNTW-1:0] cnt_ff [CLASS_COUNT];
   logic [CNTW-1:0] cnt_in [CLASS_COUNT];

   for (genvar g = 0; g < CLASS_COUNT; g++) begin : g_cnt
      always_comb begin
         cnt_in[g] = cnt_ff[g];
         if (cmd.load) begin
            cnt_in[g] = '0;
         end else if (cmd.accept && (req_sample_class == 8'(g))) begin
            cnt_in[g] = cnt_ff[g] + 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            cnt_ff[g] <= '0;
         end else begin
            cnt_ff[g] <= cnt_in[g];
         end
      end
   end

   // step counter of the class scan
   logic [STW-1:0] step_ff, step_in;

   always_comb begin
      step_in = step_ff;
      if (cmd.start) begin
         step_in = STW'(1);
      end else if (cmd.step) begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   assign status.step_last = (step_ff == STW'(LAST));

   // mean: floor(sum / FOOT) by reciprocal multiply on the magnitude,
   // biased by FOOT - 1 for negative sums
   localparam int     DIVK  = SUMW + $clog2(FOOT);
   localparam int     RCW   = SUMW + 1;
   localparam int     PRW   = SUMW + RCW;
   localparam longint RECIP = ((longint'(1) << DIVK) + longint'(FOOT) - 1)
                              / longint'(FOOT);

   logic [SUMW-1:0] mag_ff, mag_in;
   logic            neg_ff, neg_in;
   logic [15:0]     quo_ff, quo_in;
   logic [SUMW-1:0] sum_u;
   logic [RCW-1:0]  recip;
   logic [PRW-1:0]  prod;

   assign sum_u = sum_ff;
   assign recip = RCW'(RECIP);
   assign prod  = PRW'(mag_ff) * PRW'(recip);

   always_comb begin
      mag_in = mag_ff;
      neg_in = neg_ff;
      quo_in = quo_ff;
      if (cmd.start) begin
         neg_in = sum_ff[SUMW-1];
         mag_in = sum_ff[SUMW-1] ? (~sum_u + SUMW'(FOOT)) : sum_u;
      end else if (cmd.step) begin
         quo_in = prod[DIVK +: 16];
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
   end

   // majority scan, strict compare keeps the lowest index on ties
   logic [CW-1:0]   best_ff, best_in;
   logic [CNTW-1:0] best_cnt_ff, best_cnt_in;
   logic [CW-1:0]   scan_idx;
   logic [CNTW-1:0] scan_cnt;

   assign scan_idx = step_ff[CW-1:0];
   assign scan_cnt = cnt_ff[scan_idx];

   always_comb begin
      best_in     = best_ff;
      best_cnt_in = best_cnt_ff;
      if (cmd.start) begin
         best_in     = '0;
         best_cnt_in = cnt_ff[0];
      end else if (cmd.step && (step_ff <= STW'(CLASS_COUNT - 1))
                   && (scan_cnt > best_cnt_ff)) begin
         best_in     = scan_idx;
         best_cnt_in = scan_cnt;
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      best_cnt_ff <= best_cnt_in;
   end

   // result register
   logic signed [15:0] height_ff, height_in;
   logic        [3:0]  class_ff, class_in;
   logic        [CLW-1:0] best_ext;

   assign best_ext = CLW'(best_ff);

   always_comb begin
      height_in = height_ff;
      class_in  = class_ff;
      if (cmd.load) begin
         height_in = median_mode ? cell_ff[FOOT / 2] : (neg_ff ? -quo_ff : quo_ff);
         class_in  = best_ext[3:0];
      end
   end

   always_ff @(posedge clock) begin
      height_ff <= height_in;
      class_ff  <= class_in;
   end

   assign rsp_block_height = height_ff;
   assign rsp_block_class  = class_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/block_downsample_median_mean_core.sv =====
// ----------------------------------------------------------------------------
// block_downsample_median_mean_core: footprint median/mean with majority class
// One result per SAMPLES_PER_SIDE^2 samples: median or mean height and the
// most frequent valid class label.
//
//   Channel  Ports                                   Beat
//   req      req_valid/req_ready, sample fields      one sample
//   rsp      rsp_valid/rsp_ready, block fields       one footprint result
//   csr      csr_wr_en, csr_wr_data                  median_mode write
//
// Samples are taken one per cycle while req_ready is high. After the last
// sample beat come a start step, CLASS_COUNT - 1 serial class scan steps
// (the mean multiply runs alongside) and a load step; req_ready is low from
// that beat until the load. New samples are taken while a result waits; a
// stalled output holds off the next load, and req_ready stays low until it.
// Synchronous reset clears mode, counters and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module block_downsample_median_mean_core
   import bdmm_pkg::*;
#(
   parameter int SAMPLES_PER_SIDE = 4,
   parameter int CLASS_COUNT      = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_sample_height,
   input  wire logic        [7:0]  req_sample_class,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed      [15:0] rsp_block_height,
   output logic             [3:0]  rsp_block_class,
   input  wire logic               csr_wr_en,
   input  wire logic               csr_wr_data
);

   cmd_type    cmd;
   status_type status;
   logic       mode_ff, mode_in;

   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   bdmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bdmm_datapath #(
      .SAMPLES_PER_SIDE (SAMPLES_PER_SIDE),
      .CLASS_COUNT      (CLASS_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .median_mode       (mode_ff),
      .req_sample_height (req_sample_height),
      .req_sample_class  (req_sample_class),
      .rsp_block_height  (rsp_block_height),
      .rsp_block_class   (rsp_block_class)
   );

   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten while waiting");

   a_accept_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> !(cmd.start || cmd.step || cmd.load))
      else $error("sample beat taken during finishing steps");

   a_start_then_step: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> cmd.step)
      else $error("finishing steps did not follow start");

endmodule

`default_nettype wire

// ===== tb/block_downsample_median_mean_core_test.sv =====
// ----------------------------------------------------------------------------
// block_downsample_median_mean_core_test: footprint downsampler testbench
// Streams 4x4 footprints of height/class samples into the core and checks
// every result beat against a local footprint predictor. It starts with a
// table of hand-picked footprints, then runs random footprints under three
// handshake idle patterns, switching median/mean mode between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module block_downsample_median_mean_core_test;

   localparam int SIDE           = 4;
   localparam int FOOT           = SIDE * SIDE;
   localparam int CLASSES        = 16;
   localparam int RESULT_LATENCY = CLASSES + 1;
   localparam int PHASE_SAMPLES  = 250;
   localparam int PHASES         = 6;

   localparam bit MODE_MEAN   = 1'b0;
   localparam bit MODE_MEDIAN = 1'b1;

   typedef struct packed {
      logic signed [15:0] height;
      logic        [3:0]  label;
   } block_result_type;

   typedef struct packed {
      logic               mode;
      logic signed [15:0] h_first;
      logic signed [15:0] h_step;
      logic        [7:0]  c_first;
      logic        [7:0]  c_span;
      logic               known;
      logic signed [15:0] exp_height;
      logic        [3:0]  exp_label;
   } footprint_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_sample_height = '0;
   logic        [7:0]  req_sample_class = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_block_height;
   logic        [3:0]  rsp_block_class;
   logic               csr_wr_en = 1'b0;
   logic               csr_wr_data = 1'b0;

   // footprint predictor state
   bit                 mode_median;
   logic signed [15:0] foot_heights [FOOT];
   int                 label_counts [CLASSES];
   int                 foot_fill;
   int                 height_total;

   block_result_type  expected_blocks [$];
   block_result_type  want_block;
   footprint_row_type directed_rows [8];

   int send_gap_pct = 0;
   int recv_gap_pct = 0;
   int samples_sent = 0;
   int results_checked = 0;
   int mismatch_count = 0;

   block_downsample_median_mean_core #(
      .SAMPLES_PER_SIDE (SIDE),
      .CLASS_COUNT      (CLASSES)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_height (req_sample_height),
      .req_sample_class  (req_sample_class),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_block_height  (rsp_block_height),
      .rsp_block_class   (rsp_block_class),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("simulation failed");
      $finish;
   end

   function automatic void clear_footprint();
      for (int i = 0; i < CLASSES; i++) label_counts[i] = 0;
      foot_fill = 0;
      height_total = 0;
   endfunction

   // Takes one sample; returns 1 with the block result on the last one.
   function automatic bit footprint_step(input logic signed [15:0] h,
                                         input logic [7:0] c,
                                         output block_result_type blk);
      int sorted [FOOT];
      int v;
      int j;
      int best;
      foot_heights[foot_fill] = h;
      height_total += h;
      if (c < CLASSES) label_counts[c[3:0]]++;
      foot_fill++;
      blk = '0;
      if (foot_fill < FOOT) return 1'b0;
      if (mode_median) begin
         for (int i = 0; i < FOOT; i++) sorted[i] = foot_heights[i];
         for (int i = 1; i < FOOT; i++) begin
            v = sorted[i];
            j = i;
            while (j > 0 && sorted[j - 1] > v) begin
               sorted[j] = sorted[j - 1];
               j--;
            end
            sorted[j] = v;
         end
         blk.height = 16'(sorted[FOOT / 2]);
      end else if (height_total >= 0) begin
         blk.height = 16'(height_total / FOOT);
      end else begin
         blk.height = 16'(-((-height_total + FOOT - 1) / FOOT));
      end
      best = 0;
      for (int i = 1; i < CLASSES; i++)
         if (label_counts[i] > label_counts[best]) best = i;
      blk.label = best[3:0];
      clear_footprint();
      return 1'b1;
   endfunction

   task automatic send_sample(input logic signed [15:0] h, input logic [7:0] c);
      block_result_type blk;
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_sample_height = h;
      req_sample_class = c;
      do @(posedge clock); while (!req_ready);
      samples_sent++;
      if (footprint_step(h, c, blk)) expected_blocks = {expected_blocks, blk};
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 4) @(posedge clock);
   endtask

   task automatic set_mode(input bit m);
      wait_drained();
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = m;
      @(negedge clock);
      csr_wr_en = 1'b0;
      mode_median = m;
   endtask

   function automatic logic signed [15:0] random_height(input int style);
      int pick;
      logic signed [15:0] edge_value;
      pick = $urandom_range(3);
      case (pick)
         0: edge_value = 16'sh7FFF;
         1: edge_value = 16'sh8000;
         2: edge_value = 16'sh0000;
         default: edge_value = 16'shFFFF;
      endcase
      case (style)
         0: return 16'($urandom);
         1: return 16'($urandom_range(48) - 24);
         2: return edge_value;
         default: return (pick == 0) ? edge_value : 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] random_class(input int favorite);
      int r;
      r = $urandom_range(9);
      if (r == 0) return 8'($urandom);
      if (r <= 4) return 8'(favorite);
      return 8'($urandom_range(CLASSES - 1));
   endfunction

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= recv_gap_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_blocks.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat: height %0d class %0d",
                        rsp_block_height, rsp_block_class);
         end else begin
            want_block = expected_blocks.pop_front();
            results_checked++;
            if (rsp_block_height !== want_block.height ||
                rsp_block_class !== want_block.label) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result %0d: expected height %0d class %0d, got %0d %0d",
                           results_checked, want_block.height, want_block.label,
                           rsp_block_height, rsp_block_class);
            end
         end
      end
   end

   initial begin
      footprint_row_type row;
      int style;
      int favorite;
      block_result_type typed;

      // mode, first height, height step, first class, class span, known, exp
      directed_rows[0] = '{MODE_MEAN,   16'sh7FFF, 16'sd0,  8'd15,  8'd1,  1'b1,
                           16'sh7FFF, 4'd15};
      directed_rows[1] = '{MODE_MEDIAN, 16'sh8000, 16'sd0,  8'd255, 8'd1,  1'b1,
                           16'sh8000, 4'd0};
      directed_rows[2] = '{MODE_MEAN,   -16'sd8,   16'sd1,  8'd0,   8'd16, 1'b1,
                           -16'sd1,   4'd0};
      directed_rows[3] = '{MODE_MEDIAN, -16'sd8,   16'sd1,  8'd3,   8'd2,  1'b1,
                           16'sd0,    4'd3};
      directed_rows[4] = '{MODE_MEDIAN, 16'sd7,    -16'sd1, 8'd14,  8'd4,  1'b1,
                           16'sd0,    4'd14};
      directed_rows[5] = '{MODE_MEAN,   16'sh7FF0, 16'sd1,  8'd9,   8'd3,  1'b1,
                           16'sd32759, 4'd9};
      directed_rows[6] = '{MODE_MEDIAN, -16'sd100, 16'sd37, 8'd200, 8'd60, 1'b0,
                           16'sd0,    4'd0};
      directed_rows[7] = '{MODE_MEAN,   16'sh8000, 16'sd4096, 8'd5, 8'd7,  1'b0,
                           16'sd0,    4'd0};

      mode_median = MODE_MEAN;
      clear_footprint();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_gap_pct = 28;
      recv_gap_pct = 69;
      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.mode != mode_median) set_mode(row.mode);
         for (int i = 0; i < FOOT; i++)
            send_sample(16'(row.h_first + i * row.h_step),
                        8'(row.c_first + (i % row.c_span)));
         if (row.known) begin
            typed.height = row.exp_height;
            typed.label = row.exp_label;
            expected_blocks[expected_blocks.size() - 1] = typed;
         end
      end

      // phase boundaries fall mid-footprint, so mode also changes mid-footprint
      for (int p = 0; p < PHASES; p++) begin
         set_mode((p % 2 == 0) ? MODE_MEDIAN : MODE_MEAN);
         case (p / 2)
            0: begin send_gap_pct = 28; recv_gap_pct = 69; end
            1: begin send_gap_pct = 69; recv_gap_pct = 28; end
            default: begin send_gap_pct = 0; recv_gap_pct = 0; end
         endcase
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            if (n % FOOT == 0) begin
               style = $urandom_range(3);
               favorite = $urandom_range(CLASSES - 1);
            end
            send_sample(random_height(style), random_class(favorite));
         end
      end

      wait_drained();
      $display("%0d samples sent, %0d footprint results checked, %0d mismatches",
               samples_sent, results_checked, mismatch_count);
      $display("covered median and mean modes under three handshake idle patterns");
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/bdmm_pkg.sv
hw/rtl/bdmm_ctrl.sv
hw/rtl/bdmm_datapath.sv
hw/rtl/block_downsample_median_mean_core.sv
tb/block_downsample_median_mean_core_test.sv
